/* sv/awlt_pkg.sv */
package awlt_pkg;

  // Width of the ack window and of the drop counter.
  localparam int unsigned WIN_BITS = 32;
  localparam int unsigned CNT_BITS = 32;

  // Width of a per-item drop count (0..WIN_BITS).
  localparam int unsigned NOW_BITS = 6;

  // Field widths of the stream items.
  localparam int unsigned SEQ_FIELD_BITS = 16;
  localparam int unsigned IN_DATA_BITS   = 16;
  localparam int unsigned OUT_DATA_BITS  = 88;

  typedef logic [WIN_BITS-1:0] ackvec_t;
  typedef logic [NOW_BITS-1:0] now_t;

  // Number of set bits in a window word.
  function automatic now_t ones_in(input ackvec_t v);
    now_t n;
    n = '0;
    for (int i = 0; i < WIN_BITS; i++) begin
      n = n + now_t'(v[i]);
    end
    return n;
  endfunction

endpackage

/* sv/ack_window_loss_tracker.sv */
// Receive-side sequence tracker with a 32-bit ack window and loss counting.
//
// The slave stream carries one received packet sequence number per item. The
// master stream returns one item per input item: the latest sequence number,
// the ack window (bit i set means packet latest-(i+1) arrived), the saturating
// running drop total, and the number of packets judged lost by this item.
//
// An accepted item sits in an input register; once the result register is free, the window
// update (one shift, mask and population count) runs and writes the result register.
// The result shows on the master side when the result register is written, and the block
// takes one item per cycle while the master side keeps up.
// When the master stalls, the result register holds, the pending item waits in
// the input register, and s_axis_tready drops once both are full.
//
// Reset clears the tracker: the next item links it, becomes the latest number
// and fills the window with ones. Only the low SEQ_BITS bits of a sequence
// number are used; comparison is wrap-aware modulo 2^SEQ_BITS.
module ack_window_loss_tracker #(
  parameter int unsigned SEQ_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // seq_number[15:0]
  input  logic [awlt_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // latest_seq[15:0], ack_window[47:16], drops_total[79:48], drops_now[85:80],
  // zero padding[87:86]
  output logic [awlt_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);
  import awlt_pkg::*;

  localparam int unsigned EXT_BITS = (SEQ_BITS > SEQ_FIELD_BITS) ? SEQ_BITS : SEQ_FIELD_BITS;
  localparam logic [SEQ_BITS-1:0] HALF = {1'b1, {(SEQ_BITS-1){1'b0}}};
  localparam logic [SEQ_BITS-1:0] WIN_SPAN = SEQ_BITS'(WIN_BITS);
  localparam int unsigned PAD_BITS = OUT_DATA_BITS - SEQ_FIELD_BITS - WIN_BITS - CNT_BITS
                                     - NOW_BITS;

  // Input register.
  logic                      in_valid_q, in_valid_d;
  logic [SEQ_BITS-1:0]       seq_q, seq_d;

  // Tracker state.
  logic                      linked_q, linked_d;
  logic [SEQ_BITS-1:0]       newest_q, newest_d;
  ackvec_t                   window_q, window_d;
  logic [CNT_BITS-1:0]       lost_q, lost_d;

  // Result register.
  logic                      out_valid_q, out_valid_d;
  logic [SEQ_FIELD_BITS-1:0] res_seq_q, res_seq_d;
  ackvec_t                   res_window_q, res_window_d;
  logic [CNT_BITS-1:0]       res_lost_q, res_lost_d;
  now_t                      res_now_q, res_now_d;

  logic                      advance;
  logic [EXT_BITS-1:0]       in_ext;
  logic [EXT_BITS-1:0]       newest_ext;
  logic [SEQ_BITS-1:0]       fwd_dist;
  logic [SEQ_BITS-1:0]       back;
  logic                      is_newer;
  logic                      far_jump;
  logic [NOW_BITS-1:0]       dist_amt;
  logic [NOW_BITS-1:0]       back_amt;
  ackvec_t                   top_mask;
  now_t                      now;
  logic [CNT_BITS:0]         lost_sum;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  assign in_ext = EXT_BITS'(s_axis_tdata[SEQ_FIELD_BITS-1:0]);

  always_comb begin
    in_valid_d = in_valid_q;
    seq_d      = seq_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
      seq_d      = in_ext[SEQ_BITS-1:0];
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  // Wrap-aware compare: at exactly half the range, the larger number is newer.
  assign fwd_dist = seq_q - newest_q;
  assign back     = newest_q - seq_q;
  assign is_newer = (fwd_dist != '0) &&
                    ((fwd_dist < HALF) || ((fwd_dist == HALF) && (seq_q > newest_q)));
  assign far_jump = fwd_dist > WIN_SPAN;
  assign dist_amt = fwd_dist[NOW_BITS-1:0];
  assign back_amt = back[NOW_BITS-1:0];
  assign top_mask = ~(ackvec_t'({WIN_BITS{1'b1}}) >> dist_amt);

  always_comb begin
    now = '0;
    if (linked_q && is_newer && (window_q != '0)) begin
      if (far_jump) begin
        now = now_t'(WIN_BITS + 1) - ones_in(window_q);
      end else begin
        now = dist_amt - ones_in(window_q & top_mask);
      end
    end
  end

  assign lost_sum = {1'b0, lost_q} + (CNT_BITS + 1)'(now);

  always_comb begin
    linked_d = linked_q;
    newest_d = newest_q;
    window_d = window_q;
    lost_d   = lost_q;
    if (advance) begin
      if (!linked_q) begin
        linked_d = 1'b1;
        newest_d = seq_q;
        window_d = '1;
      end else if (is_newer) begin
        newest_d = seq_q;
        // A shift by the full width leaves only the old latest in the top bit.
        if (far_jump) begin
          window_d = '0;
        end else begin
          window_d = (window_q << dist_amt) | (ackvec_t'(1) << (dist_amt - now_t'(1)));
        end
        lost_d = lost_sum[CNT_BITS] ? '1 : lost_sum[CNT_BITS-1:0];
      end else if ((back != '0) && (back <= WIN_SPAN)) begin
        window_d = window_q | (ackvec_t'(1) << (back_amt - now_t'(1)));
      end
    end
  end

  assign newest_ext = EXT_BITS'(newest_d);

  always_comb begin
    out_valid_d  = out_valid_q;
    res_seq_d    = res_seq_q;
    res_window_d = res_window_q;
    res_lost_d   = res_lost_q;
    res_now_d    = res_now_q;
    if (advance) begin
      out_valid_d  = 1'b1;
      res_seq_d    = newest_ext[SEQ_FIELD_BITS-1:0];
      res_window_d = window_d;
      res_lost_d   = lost_d;
      res_now_d    = now;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      linked_q    <= 1'b0;
      newest_q    <= '0;
      window_q    <= '0;
      lost_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      linked_q    <= linked_d;
      newest_q    <= newest_d;
      window_q    <= window_d;
      lost_q      <= lost_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q        <= seq_d;
    res_seq_q    <= res_seq_d;
    res_window_q <= res_window_d;
    res_lost_q   <= res_lost_d;
    res_now_q    <= res_now_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PAD_BITS{1'b0}}, res_now_q, res_lost_q, res_window_q, res_seq_q};

endmodule

/* sim/awlt_monitor.sv */
`timescale 1ns / 100ps

// Watches both streams of the tracker, predicts every result from the accepted
// sequence numbers and compares each returned item with the oldest prediction.
module awlt_monitor #(
  parameter int unsigned SEQ_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  // seq_number[15:0]
  input  logic [awlt_pkg::IN_DATA_BITS-1:0]  in_data_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  // latest_seq[15:0], ack_window[47:16], drops_total[79:48], drops_now[85:80]
  input  logic [awlt_pkg::OUT_DATA_BITS-1:0] out_data_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);

  import awlt_pkg::*;

  typedef struct packed {
    logic [NOW_BITS-1:0]       drops_now;
    logic [CNT_BITS-1:0]       drops_total;
    ackvec_t                   ack_window;
    logic [SEQ_FIELD_BITS-1:0] latest_seq;
  } ack_item_t;

  // Shadow copy of the tracker state.
  logic                linked_q;
  logic [31:0]         latest_q;
  ackvec_t             window_q;
  logic [CNT_BITS-1:0] drops_q;

  ack_item_t ack_expect_q[$];
  int        fails;
  ack_item_t want;
  ack_item_t got;

  function automatic logic [31:0] seq_mask();
    logic [63:0] m;
    m = (64'd1 << SEQ_BITS) - 64'd1;
    return m[31:0];
  endfunction

  // Wrap-aware "a is newer than b".
  function automatic bit is_ahead(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] half;
    half = 64'd1 << (SEQ_BITS - 1);
    if (a > b) return 64'(a - b) <= half;
    if (a < b) return 64'(b - a) > half;
    return 1'b0;
  endfunction

  function automatic ack_item_t advance_window(input logic [IN_DATA_BITS-1:0] seq_raw);
    logic [31:0] seq;
    logic [31:0] fwd_dist;
    logic [31:0] back;
    logic [31:0] lost;
    logic [63:0] sum;
    ack_item_t   res;
    seq  = 32'(seq_raw) & seq_mask();
    lost = '0;
    if (!linked_q) begin
      linked_q = 1'b1;
      latest_q = seq;
      window_q = '1;
    end else if (is_ahead(seq, latest_q)) begin
      fwd_dist = (seq - latest_q) & seq_mask();
      // Zero bits leaving the top are losses, but an empty window counts none.
      if (window_q != '0) begin
        if (fwd_dist > WIN_BITS) begin
          lost = 32'd1 + WIN_BITS - 32'($countones(window_q));
        end else begin
          lost = fwd_dist - 32'($countones(window_q >> (WIN_BITS - fwd_dist)));
        end
      end
      if (fwd_dist < WIN_BITS) begin
        window_q = (window_q << fwd_dist) | (ackvec_t'(1) << (fwd_dist - 1));
      end else if (fwd_dist == WIN_BITS) begin
        window_q = ackvec_t'(1) << (WIN_BITS - 1);
      end else begin
        window_q = '0;
      end
      latest_q = seq;
      sum      = 64'(drops_q) + 64'(lost);
      drops_q  = (sum > 64'hFFFF_FFFF) ? '1 : sum[CNT_BITS-1:0];
    end else if (seq != latest_q) begin
      back = (latest_q - seq) & seq_mask();
      if (back >= 1 && back <= WIN_BITS) begin
        window_q[back-1] = 1'b1;
      end
    end
    res.latest_seq  = latest_q[SEQ_FIELD_BITS-1:0];
    res.ack_window  = window_q;
    res.drops_total = drops_q;
    res.drops_now   = lost[NOW_BITS-1:0];
    return res;
  endfunction

  function automatic bit field_ok(input string name, input logic [31:0] exp_v,
                                  input logic [31:0] act_v);
    if (exp_v === act_v) return 1'b1;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      linked_q = 1'b0;
      latest_q = '0;
      window_q = '0;
      drops_q  = '0;
      fails    = 0;
      ack_expect_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = out_data_i[$bits(ack_item_t)-1:0];
        if (ack_expect_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %h", $time, out_data_i);
          fails++;
        end else begin
          want = ack_expect_q.pop_front();
          fails += !field_ok("latest_seq", 32'(want.latest_seq), 32'(got.latest_seq));
          fails += !field_ok("ack_window", want.ack_window, got.ack_window);
          fails += !field_ok("drops_total", want.drops_total, got.drops_total);
          fails += !field_ok("drops_now", 32'(want.drops_now), 32'(got.drops_now));
        end
      end
      if (in_valid_i && in_ready_i) begin
        ack_expect_q.push_back(advance_window(in_data_i));
      end
      fail_count_o <= fails;
      pending_o    <= ack_expect_q.size();
    end
  end

endmodule

/* sim/ack_window_loss_tracker_tb.sv */
`timescale 1ns / 100ps

module ack_window_loss_tracker_tb;

  import awlt_pkg::*;

  localparam int unsigned SEQ_BITS     = 16;
  localparam int unsigned RANDOM_ITEMS = 1950;
  localparam int unsigned PHASE_ITEMS  = 150;
  localparam int unsigned IDLE_LIMIT   = 4000;

  typedef enum logic {
    PACE_FULL,
    PACE_RANDOM
  } pace_e;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;
  logic                     m_axis_tready = 1'b0;
  logic                     s_axis_tready;
  logic                     m_axis_tvalid;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;

  int    fail_count;
  int    pending_cnt;
  pace_e tx_pace     = PACE_FULL;
  pace_e rx_pace     = PACE_FULL;
  int    rx_hold     = 0;
  int    rx_roll;
  int    idle_cycles = 0;
  logic [15:0] cursor = '0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  ack_window_loss_tracker #(
    .SEQ_BITS(SEQ_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  awlt_monitor #(
    .SEQ_BITS(SEQ_BITS)
  ) u_monitor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .fail_count_o(fail_count),
    .pending_o   (pending_cnt)
  );

  // Result side: mostly ready, with short stalls and now and then a long one.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (rx_pace == PACE_FULL) begin
      m_axis_tready <= 1'b1;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 70) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        rx_hold <= (rx_roll < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Rough guess of the newest number, used only to keep the stream well formed.
  function automatic bit ahead_of(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d;
    d = a - b;
    return (d != 16'd0) && (d < 16'h8000);
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (tx_pace == PACE_FULL || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Mostly in-order traffic with small losses, some late or repeated packets,
  // a few long jumps and some noise.
  function automatic logic [15:0] pick_seq();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return cursor + 16'($urandom_range(1, 4));
    if (roll < 70) return cursor - 16'($urandom_range(0, 34));
    if (roll < 80) return cursor + 16'($urandom_range(5, 40));
    if (roll < 85) return cursor + 16'($urandom_range(41, 32768));
    if (roll < 90) return cursor + 16'h8000 + 16'($urandom_range(0, 2)) - 16'd1;
    return 16'($urandom());
  endfunction

  task automatic push_seq(input logic [15:0] seq, input int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= seq;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (ahead_of(seq, cursor)) cursor = seq;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Linking, repeat of the latest, and steps of one, 32 and 33.
    push_seq(16'd100, 0);
    push_seq(16'd100, 0);
    push_seq(16'd101, 0);
    push_seq(16'd133, 0);
    push_seq(16'd166, 0);
    // A newer number while the window is empty counts no loss.
    push_seq(16'd170, 0);
    // Late arrivals: inside the window, one past it, and at both window edges.
    push_seq(16'd168, 0);
    push_seq(16'd137, 0);
    push_seq(16'd138, 0);
    push_seq(16'd169, 0);
    push_seq(16'd65535, 0);
    // Exactly half the sequence space ahead, then exactly half behind.
    push_seq(16'd32938, 0);
    push_seq(16'd170, 0);
    push_seq(16'd65530, 0);
    push_seq(16'd65534, 0);
    // Wrap through zero, a late one across the wrap, a 32 step on a sparse window.
    push_seq(16'd3, 0);
    push_seq(16'd65535, 0);
    push_seq(16'd35, 0);
    push_seq(16'd36, 0);
    push_seq(16'd50, 0);
    push_seq(16'h5555, 0);
    push_seq(16'hAAAA, 0);
    push_seq(16'hFFFF, 0);
    push_seq(16'h0000, 0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Each phase starts with the sender held off until every result is back.
      if (n % PHASE_ITEMS == 0) begin
        drain();
        tx_pace = ((n / PHASE_ITEMS) % 4 == 1 || (n / PHASE_ITEMS) % 4 == 3) ?
                  PACE_RANDOM : PACE_FULL;
        rx_pace <= ((n / PHASE_ITEMS) % 4 >= 2) ? PACE_RANDOM : PACE_FULL;
      end
      push_seq(pick_seq(), pick_gap());
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
